### hdl/tbos_pkg.sv
// Shared types and constants for the timer bank.
// Used by the channel interfaces, the register block and the slot sequencer.
package tbos_pkg;

	localparam int REQ_W      = 2;
	localparam int NOW_W      = 32;
	localparam int TMO_W      = 31;
	localparam int TAG_W      = 16;
	localparam int SEL_W      = 4;
	localparam int KIND_W     = 3;
	localparam int BACKDATE_W = 16;

	// at most this many results for one tick
	localparam int RES_CAP = 16;
	localparam int CAP_W   = $clog2(RES_CAP + 1);

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-3:0] REG_FREE_BACKDATE = '0;
	localparam logic [BACKDATE_W-1:0] FREE_BACKDATE_RST = 16'd1000;

	typedef enum logic [REQ_W-1:0] {
		REQ_TICK  = 2'd0,
		REQ_ALLOC = 2'd1,
		REQ_FREE  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_EXPIRY  = 3'd0,
		KIND_ALLOC   = 3'd1,
		KIND_REFUSED = 3'd2,
		KIND_FREED   = 3'd3,
		KIND_IGNORED = 3'd4
	} kind_t;

	typedef struct packed {
		logic             repeat_mode;
		logic [NOW_W-1:0] start;
		logic [TMO_W-1:0] period;
		logic [TAG_W-1:0] tag;
	} slot_entry_t;

	typedef struct packed {
		kind_t            kind;
		logic [SEL_W-1:0] idx;
		logic [TAG_W-1:0] tag;
		logic             last;
	} res_t;

endpackage

### hdl/tbos_if.sv
// Valid/ready channel interfaces for request items and result items.
// Depends on tbos_pkg for field widths.
interface tbos_in_if import tbos_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [REQ_W-1:0] req_type;
	logic [NOW_W-1:0] now_ms;
	logic [TMO_W-1:0] timeout_ms;
	logic             repeat_mode;
	logic             fire_now;
	logic [TAG_W-1:0] user_tag;
	logic [SEL_W-1:0] slot_select;

	modport source(output valid, req_type, now_ms, timeout_ms, repeat_mode, fire_now,
		user_tag, slot_select, input ready);
	modport sink(input valid, req_type, now_ms, timeout_ms, repeat_mode, fire_now,
		user_tag, slot_select, output ready);
endinterface

interface tbos_out_if import tbos_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] result_kind;
	logic [SEL_W-1:0]  slot_index;
	logic [TAG_W-1:0]  slot_tag;
	logic              last_of_run;

	modport source(output valid, result_kind, slot_index, slot_tag, last_of_run,
		input ready);
	modport sink(input valid, result_kind, slot_index, slot_tag, last_of_run,
		output ready);
endinterface

### hdl/tbos_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tbos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### hdl/tbos_cfg.sv
// APB register block: holds the free backdate register.
// Depends on tbos_pkg.
module tbos_cfg import tbos_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [BACKDATE_W-1:0] free_backdate
);
	logic [BACKDATE_W-1:0] backdate_q;
	logic                  sel_backdate;

	assign pready        = 1'b1;
	assign sel_backdate  = (paddr[APB_ADDR_W-1:2] == REG_FREE_BACKDATE);
	assign free_backdate = backdate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backdate_q <= FREE_BACKDATE_RST;
		end else if (psel && penable && pwrite && pready && sel_backdate) begin
			backdate_q <= pwdata[BACKDATE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_backdate) begin
			prdata = APB_DATA_W'(backdate_q);
		end
	end
endmodule

### hdl/tbos_seq.sv
// Slot sequencer: valid bits, request decode, read-modify-write of the slot RAM,
// and the result pending/output stages. Depends on tbos_pkg, tbos_if, tbos_ram.
module tbos_seq import tbos_pkg::*; #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [BACKDATE_W-1:0] free_backdate,
	tbos_in_if.sink               item,
	tbos_out_if.source            res
);
	localparam int IDX_W = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_SLOTS);
	localparam logic [CAP_W-1:0] CAP     = CAP_W'(RES_CAP);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIND,
		ST_ALLOC_ACK,
		ST_FREE,
		ST_FLUSH
	} state_t;

	state_t                state_q, state_d;
	logic [NUM_SLOTS-1:0]  valid_q;
	logic [CNT_W-1:0]      scan_q;
	logic [IDX_W-1:0]      scan_idx;
	logic [CAP_W-1:0]      cnt_q, cnt_next;
	logic                  ev_vld_s1;
	logic [IDX_W-1:0]      ev_idx_s1;

	logic [NOW_W-1:0]      now_q;
	logic [TMO_W-1:0]      tmo_q;
	logic                  rep_q, fire_q;
	logic [TAG_W-1:0]      tag_q;
	logic [SEL_W-1:0]      sel_q;

	res_t                  pend_q, out_q, new_res;
	logic                  pend_vld_q, out_vld_q;
	logic                  out_free, can_emit, emit, flush_mv;

	logic                  ram_we, ram_re;
	logic [IDX_W-1:0]      ram_waddr, ram_raddr;
	slot_entry_t           ram_wdata, rd;
	logic                  take, sel_ok, due, stall, issue, scan_inc;
	logic                  set_vld, clr_vld;
	logic [NOW_W-1:0]      elapsed;

	tbos_ram #(
		.WIDTH($bits(slot_entry_t)),
		.DEPTH(NUM_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(rd)
	);

	assign item.ready = (state_q == ST_IDLE);
	assign take       = item.valid && item.ready;
	assign scan_idx   = scan_q[IDX_W-1:0];
	assign sel_ok     = (32'(item.slot_select) < 32'(NUM_SLOTS)) &&
		valid_q[IDX_W'(item.slot_select)];

	assign out_free = !out_vld_q || res.ready;
	assign can_emit = !pend_vld_q || out_free;

	assign elapsed  = now_q - rd.start;
	assign due      = ev_vld_s1 && (elapsed >= {1'b0, rd.period});
	assign stall    = due && !can_emit;
	assign cnt_next = cnt_q + CAP_W'(due);
	assign issue    = (scan_q < LAST_CNT) && (cnt_next < CAP);

	always_comb begin
		state_d   = state_q;
		emit      = 1'b0;
		new_res   = '{kind: KIND_EXPIRY, idx: '0, tag: '0, last: 1'b0};
		flush_mv  = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = ev_idx_s1;
		ram_wdata = rd;
		ram_re    = 1'b0;
		ram_raddr = scan_idx;
		set_vld   = 1'b0;
		clr_vld   = 1'b0;
		scan_inc  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (take) begin
					unique case (req_t'(item.req_type))
						REQ_TICK: begin
							state_d = ST_SCAN;
						end
						REQ_ALLOC: begin
							if (item.timeout_ms == '0) begin
								emit         = 1'b1;
								new_res.kind = KIND_REFUSED;
								state_d      = ST_FLUSH;
							end else begin
								state_d = ST_FIND;
							end
						end
						REQ_FREE: begin
							if (sel_ok) begin
								ram_re    = 1'b1;
								ram_raddr = IDX_W'(item.slot_select);
								state_d   = ST_FREE;
							end else begin
								emit         = 1'b1;
								new_res.kind = KIND_IGNORED;
								new_res.idx  = item.slot_select;
								state_d      = ST_FLUSH;
							end
						end
						REQ_NONE: begin
							state_d = ST_IDLE;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (!stall) begin
					if (due) begin
						emit        = 1'b1;
						new_res.idx = SEL_W'(ev_idx_s1);
						new_res.tag = rd.tag;
						if (rd.repeat_mode) begin
							ram_we          = 1'b1;
							ram_wdata.start = now_q;
						end else begin
							clr_vld = 1'b1;
						end
					end
					if (issue) begin
						ram_re   = 1'b1;
						scan_inc = 1'b1;
					end else begin
						state_d = ST_FLUSH;
					end
				end
			end
			ST_FIND: begin
				if (scan_q == LAST_CNT) begin
					emit         = 1'b1;
					new_res.kind = KIND_REFUSED;
					state_d      = ST_FLUSH;
				end else if (!valid_q[scan_idx]) begin
					ram_we    = 1'b1;
					ram_waddr = scan_idx;
					ram_wdata = '{repeat_mode: rep_q, start: now_q, period: tmo_q, tag: tag_q};
					set_vld   = 1'b1;
					emit      = 1'b1;
					new_res.idx = SEL_W'(scan_idx);
					new_res.tag = tag_q;
					if (fire_q) begin
						state_d = ST_ALLOC_ACK;
					end else begin
						new_res.kind = KIND_ALLOC;
						state_d      = ST_FLUSH;
					end
				end else begin
					scan_inc = 1'b1;
				end
			end
			ST_ALLOC_ACK: begin
				if (can_emit) begin
					emit         = 1'b1;
					new_res.kind = KIND_ALLOC;
					new_res.idx  = SEL_W'(scan_idx);
					new_res.tag  = tag_q;
					state_d      = ST_FLUSH;
				end
			end
			ST_FREE: begin
				// entry read at accept is in rd now
				ram_we                = 1'b1;
				ram_waddr             = IDX_W'(sel_q);
				ram_wdata.repeat_mode = 1'b0;
				ram_wdata.start       = now_q - NOW_W'(free_backdate);
				emit                  = 1'b1;
				new_res.kind          = KIND_FREED;
				new_res.idx           = sel_q;
				new_res.tag           = rd.tag;
				state_d               = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (!pend_vld_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					flush_mv = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			scan_q     <= '0;
			cnt_q      <= '0;
			ev_vld_s1  <= 1'b0;
			pend_q     <= '0;
			out_q      <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (take) begin
				scan_q    <= '0;
				cnt_q     <= '0;
				ev_vld_s1 <= 1'b0;
			end else if (state_q == ST_SCAN && !stall) begin
				cnt_q     <= cnt_next;
				ev_vld_s1 <= issue && valid_q[scan_idx];
			end
			if (scan_inc) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (set_vld) begin
				valid_q[scan_idx] <= 1'b1;
			end
			if (clr_vld) begin
				valid_q[ev_idx_s1] <= 1'b0;
			end
			// pending holds the newest result until we know whether it ends the run
			priority if (flush_mv) begin
				out_q      <= '{kind: pend_q.kind, idx: pend_q.idx, tag: pend_q.tag,
					last: 1'b1};
				out_vld_q  <= 1'b1;
				pend_vld_q <= 1'b0;
			end else if (emit && pend_vld_q) begin
				out_q      <= '{kind: pend_q.kind, idx: pend_q.idx, tag: pend_q.tag,
					last: 1'b0};
				out_vld_q  <= 1'b1;
				pend_q     <= new_res;
			end else if (emit) begin
				pend_q     <= new_res;
				pend_vld_q <= 1'b1;
				if (res.ready) begin
					out_vld_q <= 1'b0;
				end
			end else if (res.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			now_q  <= item.now_ms;
			tmo_q  <= item.timeout_ms;
			rep_q  <= item.repeat_mode;
			fire_q <= item.fire_now;
			tag_q  <= item.user_tag;
			sel_q  <= item.slot_select;
		end
		if (state_q == ST_SCAN && !stall && issue) begin
			ev_idx_s1 <= scan_idx;
		end
	end

	assign res.valid       = out_vld_q;
	assign res.result_kind = out_q.kind;
	assign res.slot_index  = out_q.idx;
	assign res.slot_tag    = out_q.tag;
	assign res.last_of_run = out_q.last;

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ram_waddr != ram_raddr)
		else $error("slot RAM read and write hit the same entry");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP)
		else $error("tick produced more results than the cap");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !pend_vld_q)
		else $error("new item accepted with a result still pending");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN && ev_vld_s1 |-> CNT_W'(ev_idx_s1) < scan_q)
		else $error("evaluated slot is not behind the scan pointer");
endmodule

### hdl/timer_bank_one_shot_periodic.sv
// Timer bank with NUM_SLOTS one-shot or periodic slots. The slot contents sit in one
// RAM with a registered read; valid bits are flops cleared at reset, so the bank is
// usable right after reset with no clearing pass. One request is in work at a time.
// A tick reads one slot per cycle through the RAM read port while the output is not
// backed up. An allocate walks the valid bits one per cycle from slot 0; a zero
// timeout is refused without a walk, and a free of an empty or out-of-range slot is
// ignored without a RAM read. A request takes longer while results back up at the
// output. The last result of each request that yields results carries last_of_run.
// A new request is taken while the final result still waits in the output register.
module timer_bank_one_shot_periodic import tbos_pkg::*; #(
	parameter int NUM_SLOTS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tbos_in_if.sink               item,
	tbos_out_if.source            res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);
	logic [BACKDATE_W-1:0] free_backdate;

	tbos_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.free_backdate(free_backdate)
	);

	tbos_seq #(
		.NUM_SLOTS(NUM_SLOTS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.free_backdate(free_backdate),
		.item         (item),
		.res          (res)
	);
endmodule

### tb/sv/tb_timer_bank_one_shot_periodic.sv
// Self-checking testbench for the timer bank: drives request beats, predicts the result beats
// and compares them; configures the backdate register over APB between phases.
// Depends on tbos_pkg, tbos_in_if / tbos_out_if and timer_bank_one_shot_periodic.
`timescale 1ns / 100ps

module tb_timer_bank_one_shot_periodic;
	import tbos_pkg::*;

	localparam int NUM_SLOTS      = 16;
	localparam int LIMIT_CYCLES   = 400000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int RX_HOLD_CYCLES = 400;
	localparam int MAX_PRINTS     = 100;

	typedef struct packed {
		req_t             req;
		logic [NOW_W-1:0] now;
		logic [TMO_W-1:0] tmo;
		logic             rep;
		logic             fire;
		logic [TAG_W-1:0] tag;
		logic [SEL_W-1:0] sel;
	} req_item_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	tbos_in_if  item_ch();
	tbos_out_if res_ch();

	timer_bank_one_shot_periodic #(.NUM_SLOTS(NUM_SLOTS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.res(res_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// predicted bank contents
	logic                  slot_valid [NUM_SLOTS];
	logic                  slot_repeat[NUM_SLOTS];
	logic [NOW_W-1:0]      slot_start [NUM_SLOTS];
	logic [TMO_W-1:0]      slot_period[NUM_SLOTS];
	logic [TAG_W-1:0]      slot_tag   [NUM_SLOTS];
	logic [BACKDATE_W-1:0] backdate_ms;

	req_item_t send_queue[$];
	res_t      exp_results[$];
	req_item_t next_req;
	req_item_t taken_req;
	res_t      want;
	logic      in_taken;
	logic [NOW_W-1:0] clock_ms;
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned err_count;
	int unsigned cycle_count;
	logic rx_hold_req;
	logic rx_hold;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] exp_val);
		if (err_count < MAX_PRINTS)
			$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, exp_val);
		err_count++;
	endtask

	function automatic res_t make_res(input kind_t kind, input logic [SEL_W-1:0] idx,
		input logic [TAG_W-1:0] tag);
		res_t r;
		r.kind = kind;
		r.idx  = idx;
		r.tag  = tag;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void predict_results(input req_item_t it);
		res_t run[RES_CAP + 1];
		int n;
		int found;
		logic [NOW_W-1:0] elapsed;
		n = 0;
		found = NUM_SLOTS;
		case (it.req)
			REQ_TICK: begin
				// ascending slot order, capped per tick
				for (int i = 0; i < NUM_SLOTS && n < RES_CAP; i++) begin
					if (slot_valid[i]) begin
						elapsed = it.now - slot_start[i];
						if (elapsed >= {1'b0, slot_period[i]}) begin
							run[n] = make_res(KIND_EXPIRY, SEL_W'(i), slot_tag[i]);
							n++;
							if (slot_repeat[i])
								slot_start[i] = it.now;
							else
								slot_valid[i] = 1'b0;
						end
					end
				end
			end
			REQ_ALLOC: begin
				if (it.tmo != '0) begin
					for (int i = 0; i < NUM_SLOTS; i++)
						if (!slot_valid[i] && found == NUM_SLOTS)
							found = i;
				end
				if (found == NUM_SLOTS) begin
					run[n] = make_res(KIND_REFUSED, '0, '0);
					n++;
				end else begin
					slot_valid[found]  = 1'b1;
					slot_repeat[found] = it.rep;
					slot_start[found]  = it.now;
					slot_period[found] = it.tmo;
					slot_tag[found]    = it.tag;
					if (it.fire) begin
						run[n] = make_res(KIND_EXPIRY, SEL_W'(found), it.tag);
						n++;
					end
					run[n] = make_res(KIND_ALLOC, SEL_W'(found), it.tag);
					n++;
				end
			end
			REQ_FREE: begin
				if (slot_valid[it.sel]) begin
					slot_repeat[it.sel] = 1'b0;
					slot_start[it.sel]  = it.now - {{(NOW_W-BACKDATE_W){1'b0}}, backdate_ms};
					run[n] = make_res(KIND_FREED, it.sel, slot_tag[it.sel]);
				end else begin
					run[n] = make_res(KIND_IGNORED, it.sel, '0);
				end
				n++;
			end
			default: ;
		endcase
		if (n > 0)
			run[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			exp_results.push_back(run[i]);
	endfunction

	// request driver: hold the beat until taken, then maybe idle before the next one
	always @(negedge clk) begin
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
		end else if (!item_ch.valid || in_taken) begin
			if (send_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_req = send_queue.pop_front();
				item_ch.valid       <= 1'b1;
				item_ch.req_type    <= next_req.req;
				item_ch.now_ms      <= next_req.now;
				item_ch.timeout_ms  <= next_req.tmo;
				item_ch.repeat_mode <= next_req.rep;
				item_ch.fire_now    <= next_req.fire;
				item_ch.user_tag    <= next_req.tag;
				item_ch.slot_select <= next_req.sel;
			end else begin
				item_ch.valid <= 1'b0;
			end
		end
	end

	// result receiver backpressure
	always @(negedge clk) begin
		if (!arst_n || rx_hold)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin : rx_hold_proc
		rx_hold = 1'b0;
		wait (rx_hold_req);
		rx_hold = 1'b1;
		repeat (RX_HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	// monitor: predict on each request beat, check each result beat
	always @(posedge clk) begin
		in_taken <= item_ch.valid && item_ch.ready;
		if (arst_n && item_ch.valid && item_ch.ready) begin
			taken_req.req  = req_t'(item_ch.req_type);
			taken_req.now  = item_ch.now_ms;
			taken_req.tmo  = item_ch.timeout_ms;
			taken_req.rep  = item_ch.repeat_mode;
			taken_req.fire = item_ch.fire_now;
			taken_req.tag  = item_ch.user_tag;
			taken_req.sel  = item_ch.slot_select;
			predict_results(taken_req);
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (exp_results.size() == 0) begin
				report_mismatch("result beat with nothing expected",
					32'(res_ch.result_kind), 32'd0);
			end else begin
				want = exp_results.pop_front();
				if (res_ch.result_kind !== want.kind)
					report_mismatch("result_kind", 32'(res_ch.result_kind),
						32'(want.kind));
				if (res_ch.slot_index !== want.idx)
					report_mismatch("slot_index", 32'(res_ch.slot_index), 32'(want.idx));
				if (res_ch.slot_tag !== want.tag)
					report_mismatch("slot_tag", 32'(res_ch.slot_tag), 32'(want.tag));
				if (res_ch.last_of_run !== want.last)
					report_mismatch("last_of_run", 32'(res_ch.last_of_run),
						32'(want.last));
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL timer_bank_one_shot_periodic");
		$finish;
	end

	task automatic write_backdate(input logic [BACKDATE_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_FREE_BACKDATE, 2'b00};
		pwdata  <= {{(APB_DATA_W-BACKDATE_W){1'b0}}, value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		backdate_ms = value;
		// read back
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[BACKDATE_W-1:0] !== value)
			report_mismatch("free_backdate_ms readback", prdata, 32'(value));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (send_queue.size() != 0 || item_ch.valid || exp_results.size() != 0)
			@(posedge clk);
		// a tick with nothing due leaves no result behind to wait for
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic req_item_t rand_req(input req_t kind);
		req_item_t r;
		r.req  = kind;
		r.now  = clock_ms;
		r.tmo  = TMO_W'($urandom);
		r.rep  = 1'($urandom);
		r.fire = 1'($urandom);
		r.tag  = TAG_W'($urandom);
		r.sel  = SEL_W'($urandom);
		return r;
	endfunction

	task automatic queue_directed_reqs();
		req_item_t r;
		clock_ms = 32'hFFFF_FFF0;
		r = rand_req(REQ_ALLOC);
		r.tmo = '0;
		send_queue.push_back(r);
		r = rand_req(REQ_ALLOC);
		r.tmo = 31'd1; r.rep = 1'b1; r.fire = 1'b1; r.tag = '1;
		send_queue.push_back(r);
		r = rand_req(REQ_ALLOC);
		r.tmo = '1; r.rep = 1'b0; r.fire = 1'b0; r.tag = '0;
		send_queue.push_back(r);
		send_queue.push_back(rand_req(REQ_TICK));
		clock_ms += 1;
		send_queue.push_back(rand_req(REQ_TICK));
		r = rand_req(REQ_FREE);
		r.sel = 4'd15;
		send_queue.push_back(r);
		r = rand_req(REQ_FREE);
		r.sel = 4'd1;
		send_queue.push_back(r);
		r = rand_req(REQ_NONE);
		r.now = '1; r.tmo = '1; r.rep = 1'b1; r.fire = 1'b1; r.tag = '1; r.sel = '1;
		send_queue.push_back(r);
		// fill the bank with long timeouts, then one allocate too many
		for (int i = 2; i < NUM_SLOTS; i++) begin
			r = rand_req(REQ_ALLOC);
			r.tmo  = '1;
			r.rep  = i[0];
			r.fire = (i % 3 == 0);
			send_queue.push_back(r);
		end
		r = rand_req(REQ_ALLOC);
		r.tmo = 31'd5;
		send_queue.push_back(r);
		// jump across the wrap so every slot is due at once
		clock_ms += 32'h8000_0000;
		send_queue.push_back(rand_req(REQ_TICK));
		r = rand_req(REQ_FREE);
		r.sel = 4'd0;
		send_queue.push_back(r);
	endtask

	task automatic queue_random_reqs(input int unsigned count);
		req_item_t r;
		int unsigned queued;
		int unsigned pick;
		int unsigned runlen;
		int unsigned tsel;
		queued = 0;
		while (queued < count) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				runlen = $urandom_range(1, 4);
				repeat (runlen) begin
					clock_ms += $urandom_range(0, 300);
					send_queue.push_back(rand_req(REQ_TICK));
					queued++;
				end
			end else if (pick < 60) begin
				runlen = $urandom_range(1, 3);
				repeat (runlen) begin
					clock_ms += $urandom_range(0, 20);
					r = rand_req(REQ_ALLOC);
					tsel = $urandom_range(99);
					if (tsel < 5)
						r.tmo = '0;
					else if (tsel < 8)
						r.tmo = '1;
					else if (tsel < 13)
						r.tmo = TMO_W'($urandom);
					else
						r.tmo = TMO_W'($urandom_range(1, 600));
					send_queue.push_back(r);
					queued++;
				end
			end else if (pick < 68) begin
				// burst that overfills the bank
				repeat (NUM_SLOTS + 1) begin
					r = rand_req(REQ_ALLOC);
					r.tmo = TMO_W'($urandom_range(500, 3000));
					send_queue.push_back(r);
					queued++;
				end
			end else if (pick < 82) begin
				clock_ms += $urandom_range(0, 50);
				send_queue.push_back(rand_req(REQ_FREE));
				queued++;
			end else if (pick < 88) begin
				clock_ms += $urandom;
				send_queue.push_back(rand_req(REQ_TICK));
				queued++;
			end else if (pick < 94) begin
				r = rand_req(req_t'($urandom_range(0, 2)));
				r.now = $urandom;
				send_queue.push_back(r);
				queued++;
			end else begin
				send_queue.push_back(rand_req(REQ_NONE));
			end
		end
	endtask

	initial begin : stimulus
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		item_ch.valid       = 1'b0;
		item_ch.req_type    = '0;
		item_ch.now_ms      = '0;
		item_ch.timeout_ms  = '0;
		item_ch.repeat_mode = 1'b0;
		item_ch.fire_now    = 1'b0;
		item_ch.user_tag    = '0;
		item_ch.slot_select = '0;
		res_ch.ready  = 1'b0;
		in_taken      = 1'b0;
		err_count     = 0;
		rx_hold_req   = 1'b0;
		send_idle_pct = 6;
		recv_idle_pct = 66;
		backdate_ms   = FREE_BACKDATE_RST;
		for (int i = 0; i < NUM_SLOTS; i++)
			slot_valid[i] = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// directed part runs on the reset value of the backdate
		queue_directed_reqs();
		wait_idle();

		write_backdate('0);
		queue_random_reqs(140);
		wait_idle();

		send_idle_pct = 66;
		recv_idle_pct = 6;
		write_backdate('1);
		queue_random_reqs(140);
		wait_idle();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_backdate(BACKDATE_W'($urandom));
		queue_random_reqs(110);
		wait_idle();

		// stall the receiver while requests keep coming
		write_backdate(16'd1);
		rx_hold_req = 1'b1;
		queue_random_reqs(40);
		wait_idle();

		if (err_count == 0)
			$display("PASS timer_bank_one_shot_periodic");
		else
			$display("FAIL timer_bank_one_shot_periodic");
		$finish;
	end

endmodule
